/* design/bni_pkg.sv */
// ----------------------------------------------------------------------------
// Barycentric normal interpolator package
// Shared widths, micro-op table of the multiply-accumulate sequence and the
// saturation helpers.
// ----------------------------------------------------------------------------
package bni_pkg;

   localparam int COORD_WIDTH_DEF  = 32;
   localparam int NORMAL_WIDTH_DEF = 16;

   localparam int FRAC_BITS  = 14;
   localparam int SCALED_W   = FRAC_BITS + 1;
   localparam int SHIFT_JUMP = 8;
   localparam int MUL_W      = 32;
   localparam int ACC_W      = 64;
   localparam int OUT_W      = 18;
   localparam int DIV_STEPS  = OUT_W;
   localparam int ONE_Q14    = 1 << FRAC_BITS;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   localparam int OP_CNT_W = 5;
   localparam logic [OP_CNT_W-1:0] FIRST_OP1 = 5'd0;
   localparam logic [OP_CNT_W-1:0] LAST_OP1  = 5'd20;
   localparam logic [OP_CNT_W-1:0] FIRST_OP2 = 5'd21;
   localparam logic [OP_CNT_W-1:0] LAST_OP2  = 5'd29;

   typedef enum logic [4:0] {
      OPD_E0, OPD_E1, OPD_E2, OPD_E3, OPD_E4, OPD_E5, OPD_E6, OPD_E7, OPD_E8,
      OPD_D00, OPD_D01, OPD_D11, OPD_D20, OPD_D21,
      OPD_WU, OPD_WV, OPD_WW,
      OPD_NA0, OPD_NA1, OPD_NA2, OPD_NB0, OPD_NB1, OPD_NB2,
      OPD_NC0, OPD_NC1, OPD_NC2
   } operand_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_D00, DST_D01, DST_D11, DST_D20, DST_D21,
      DST_DEN, DST_NUMV, DST_NUMW, DST_NX, DST_NY, DST_NZ
   } dest_type;

   typedef struct packed {
      operand_type src_a;
      operand_type src_b;
      logic        neg;
      logic        first;
      dest_type    dst;
   } mac_op_type;

   typedef struct packed {
      logic en;
      logic first;
      logic neg;
   } mac_ctrl_type;

   // Dot products, denominator and numerators, then the three normal sums.
   function automatic mac_op_type mac_op(input logic [OP_CNT_W-1:0] idx);
      mac_op_type op;
      op = '{OPD_E0, OPD_E0, 1'b0, 1'b0, DST_NONE};
      unique case (idx)
         5'd0:  op = '{OPD_E0,  OPD_E0,  1'b0, 1'b1, DST_NONE};
         5'd1:  op = '{OPD_E1,  OPD_E1,  1'b0, 1'b0, DST_NONE};
         5'd2:  op = '{OPD_E2,  OPD_E2,  1'b0, 1'b0, DST_D00};
         5'd3:  op = '{OPD_E0,  OPD_E3,  1'b0, 1'b1, DST_NONE};
         5'd4:  op = '{OPD_E1,  OPD_E4,  1'b0, 1'b0, DST_NONE};
         5'd5:  op = '{OPD_E2,  OPD_E5,  1'b0, 1'b0, DST_D01};
         5'd6:  op = '{OPD_E3,  OPD_E3,  1'b0, 1'b1, DST_NONE};
         5'd7:  op = '{OPD_E4,  OPD_E4,  1'b0, 1'b0, DST_NONE};
         5'd8:  op = '{OPD_E5,  OPD_E5,  1'b0, 1'b0, DST_D11};
         5'd9:  op = '{OPD_E6,  OPD_E0,  1'b0, 1'b1, DST_NONE};
         5'd10: op = '{OPD_E7,  OPD_E1,  1'b0, 1'b0, DST_NONE};
         5'd11: op = '{OPD_E8,  OPD_E2,  1'b0, 1'b0, DST_D20};
         5'd12: op = '{OPD_E6,  OPD_E3,  1'b0, 1'b1, DST_NONE};
         5'd13: op = '{OPD_E7,  OPD_E4,  1'b0, 1'b0, DST_NONE};
         5'd14: op = '{OPD_E8,  OPD_E5,  1'b0, 1'b0, DST_D21};
         5'd15: op = '{OPD_D00, OPD_D11, 1'b0, 1'b1, DST_NONE};
         5'd16: op = '{OPD_D01, OPD_D01, 1'b1, 1'b0, DST_DEN};
         5'd17: op = '{OPD_D11, OPD_D20, 1'b0, 1'b1, DST_NONE};
         5'd18: op = '{OPD_D01, OPD_D21, 1'b1, 1'b0, DST_NUMV};
         5'd19: op = '{OPD_D00, OPD_D21, 1'b0, 1'b1, DST_NONE};
         5'd20: op = '{OPD_D01, OPD_D20, 1'b1, 1'b0, DST_NUMW};
         5'd21: op = '{OPD_WU,  OPD_NA0, 1'b0, 1'b1, DST_NONE};
         5'd22: op = '{OPD_WV,  OPD_NB0, 1'b0, 1'b0, DST_NONE};
         5'd23: op = '{OPD_WW,  OPD_NC0, 1'b0, 1'b0, DST_NX};
         5'd24: op = '{OPD_WU,  OPD_NA1, 1'b0, 1'b1, DST_NONE};
         5'd25: op = '{OPD_WV,  OPD_NB1, 1'b0, 1'b0, DST_NONE};
         5'd26: op = '{OPD_WW,  OPD_NC1, 1'b0, 1'b0, DST_NY};
         5'd27: op = '{OPD_WU,  OPD_NA2, 1'b0, 1'b1, DST_NONE};
         5'd28: op = '{OPD_WV,  OPD_NB2, 1'b0, 1'b0, DST_NONE};
         5'd29: op = '{OPD_WW,  OPD_NC2, 1'b0, 1'b0, DST_NZ};
         default: op = '{OPD_E0, OPD_E0, 1'b0, 1'b0, DST_NONE};
      endcase
      return op;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] x);
      logic signed [OUT_W-1:0] r;
      if (x > ACC_W'(OUT_MAX)) begin
         r = OUT_MAX;
      end else if (x < ACC_W'(OUT_MIN)) begin
         r = OUT_MIN;
      end else begin
         r = x[OUT_W-1:0];
      end
      return r;
   endfunction

   // Divide by 2^14, rounding toward zero.
   function automatic logic signed [ACC_W-1:0] shrink_frac(input logic signed [ACC_W-1:0] x);
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] sh;
      mag = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
      sh  = mag >> FRAC_BITS;
      return x[ACC_W-1] ? -signed'(sh) : signed'(sh);
   endfunction

endpackage

/* design/bni_mac.sv */
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One signed 32x32 multiplier feeding a 64-bit accumulator register.
// ----------------------------------------------------------------------------
module bni_mac import bni_pkg::*; (
   input  logic                    clock,
   input  mac_ctrl_type            ctrl,
   input  logic signed [MUL_W-1:0] opa,
   input  logic signed [MUL_W-1:0] opb,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [ACC_W-1:0] prod;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   assign prod = opa * opb;

   always_comb begin
      acc_in = (ctrl.first ? '0 : acc_ff) + (ctrl.neg ? -prod : prod);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

/* design/bni_div.sv */
// ----------------------------------------------------------------------------
// Restoring fraction divider
// Forms num * 2^14 / den one quotient bit per cycle, rounded toward zero
// and saturated to the 18-bit weight range.
// ----------------------------------------------------------------------------
module bni_div import bni_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] num,
   input  logic signed [ACC_W-1:0] den,
   output logic                    done,
   output logic signed [OUT_W-1:0] quot
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff;
   logic [ACC_W-1:0] rem_ff, dvs_ff;
   logic [OUT_W-1:0] q_ff;
   logic [ACC_W:0]   diff;
   logic             ge;
   logic [ACC_W-1:0] num_mag;
   logic             load;

   assign load    = start && !busy_ff;
   assign num_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
   assign diff    = {1'b0, rem_ff} - {1'b0, dvs_ff};
   assign ge      = ~diff[ACC_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // The divisor starts at 8*den, so a set top quotient bit means the
   // magnitude reached eight times the denominator and the weight saturates.
   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= num_mag;
         dvs_ff <= ACC_W'(den) << 3;
         neg_ff <= num[ACC_W-1];
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= (ge ? diff[ACC_W-1:0] : rem_ff) << 1;
         q_ff   <= {q_ff[OUT_W-2:0], ge};
      end
   end

   always_comb begin
      if (q_ff[OUT_W-1]) begin
         quot = neg_ff ? OUT_MIN : OUT_MAX;
      end else begin
         quot = neg_ff ? -signed'(q_ff) : signed'(q_ff);
      end
   end

   assign done = done_ff;

endmodule

/* design/barycentric_normal_interpolator.sv */
// Slot 0 and slot 1 words are stored when accepted; the block is ready again next cycle.
// A slot 2 word's result waits on the block-scaling shifts (by edge size), the single
// multiplier (30 passes) and the bit-serial divider (two runs); a degenerate triangle
// skips the divider runs and the normal sums.
// One triangle is in flight at a time. Synchronous reset clears control state only;
// stored corners are undefined until written.
// ----------------------------------------------------------------------------
// Barycentric normal interpolator
// Gathers three corners, scales the edges, forms dot products and weights on
// a shared multiply-accumulate unit and a serial divider, then blends normals.
// ----------------------------------------------------------------------------
module barycentric_normal_interpolator import bni_pkg::*; #(
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
   parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_vertex_slot,
   input  logic signed [COORD_WIDTH-1:0]  req_vert_x,
   input  logic signed [COORD_WIDTH-1:0]  req_vert_y,
   input  logic signed [COORD_WIDTH-1:0]  req_vert_z,
   input  logic signed [NORMAL_WIDTH-1:0] req_norm_x,
   input  logic signed [NORMAL_WIDTH-1:0] req_norm_y,
   input  logic signed [NORMAL_WIDTH-1:0] req_norm_z,
   input  logic signed [COORD_WIDTH-1:0]  req_hit_x,
   input  logic signed [COORD_WIDTH-1:0]  req_hit_y,
   input  logic signed [COORD_WIDTH-1:0]  req_hit_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [OUT_W-1:0]        rsp_out_norm_x,
   output logic signed [OUT_W-1:0]        rsp_out_norm_y,
   output logic signed [OUT_W-1:0]        rsp_out_norm_z,
   output logic signed [OUT_W-1:0]        rsp_weight_u,
   output logic signed [OUT_W-1:0]        rsp_weight_v,
   output logic signed [OUT_W-1:0]        rsp_weight_w,
   output logic                           rsp_degenerate
);

   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam logic [1:0] SLOT_A = 2'd0;
   localparam logic [1:0] SLOT_B = 2'd1;
   localparam logic [1:0] SLOT_C = 2'd2;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_ABS    = 13'b0000000000010,
      ST_SCALE  = 13'b0000000000100,
      ST_FIX    = 13'b0000000001000,
      ST_MAC1   = 13'b0000000010000,
      ST_DRAIN1 = 13'b0000000100000,
      ST_CHECK  = 13'b0000001000000,
      ST_DIVV   = 13'b0000010000000,
      ST_DIVW   = 13'b0000100000000,
      ST_UCALC  = 13'b0001000000000,
      ST_MAC2   = 13'b0010000000000,
      ST_DRAIN2 = 13'b0100000000000,
      ST_OUT    = 13'b1000000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [OP_CNT_W-1:0]     op_ff, op_in;
   dest_type                wr_dst_ff, wr_dst_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic signed [COORD_WIDTH-1:0]  pos_ff [6];
   logic signed [NORMAL_WIDTH-1:0] nrm_ff [6];
   logic signed [NORMAL_WIDTH-1:0] nc_ff  [3];
   logic signed [DIFF_W-1:0]       e_ff   [9];
   logic [DIFF_W-1:0]              mag_ff [9];
   logic                           sgn_ff [9];
   logic [DIFF_W-1:0]              mag_or_ff;
   logic signed [SCALED_W-1:0]     es_ff  [9];
   logic [DIFF_W-1:0]              abs_c  [9];
   logic [DIFF_W-1:0]              or_c;

   logic signed [MUL_W-1:0] d00_ff, d01_ff, d11_ff, d20_ff, d21_ff;
   logic signed [ACC_W-1:0] den_ff, numv_ff, numw_ff;
   logic signed [OUT_W-1:0] wu_ff, wv_ff, ww_ff, nx_ff, ny_ff, nz_ff;
   logic                    deg_ff;

   logic signed [OUT_W-1:0] rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic signed [OUT_W-1:0] rsp_wu_ff, rsp_wv_ff, rsp_ww_ff;
   logic                    rsp_deg_ff;

   logic                    accept, store_corner, start_tri;
   logic                    hi8, hi1, out_load;
   mac_op_type              cur_op;
   mac_ctrl_type            mac_ctrl;
   logic signed [MUL_W-1:0] opa, opb;
   logic signed [ACC_W-1:0] acc;
   logic signed [OUT_W-1:0] acc_sat;
   logic signed [OUT_W-1:0] u_sat;
   logic                    div_start, div_done;
   logic signed [ACC_W-1:0] div_num;
   logic signed [OUT_W-1:0] div_quot;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign store_corner = accept && (req_vertex_slot == SLOT_A || req_vertex_slot == SLOT_B);
   assign start_tri    = accept && (req_vertex_slot == SLOT_C);

   // Corner store: slot 0 goes to entries 0..2, slot 1 to entries 3..5.
   always_ff @(posedge clock) begin
      if (store_corner) begin
         if (req_vertex_slot == SLOT_B) begin
            pos_ff[3] <= req_vert_x; pos_ff[4] <= req_vert_y; pos_ff[5] <= req_vert_z;
            nrm_ff[3] <= req_norm_x; nrm_ff[4] <= req_norm_y; nrm_ff[5] <= req_norm_z;
         end else begin
            pos_ff[0] <= req_vert_x; pos_ff[1] <= req_vert_y; pos_ff[2] <= req_vert_z;
            nrm_ff[0] <= req_norm_x; nrm_ff[1] <= req_norm_y; nrm_ff[2] <= req_norm_z;
         end
      end
   end

   // Edge vectors, their magnitudes, and the block-scaling shift.
   always_comb begin
      or_c = '0;
      for (int i = 0; i < 9; i++) begin
         abs_c[i] = e_ff[i][DIFF_W-1] ? DIFF_W'(-e_ff[i]) : DIFF_W'(e_ff[i]);
         or_c     = or_c | abs_c[i];
      end
   end

   // The highest set bit of the OR of all magnitudes is that of the largest one.
   assign hi8 = |(mag_or_ff >> (FRAC_BITS + SHIFT_JUMP));
   assign hi1 = |(mag_or_ff >> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (start_tri) begin
         e_ff[0] <= DIFF_W'(pos_ff[3]) - DIFF_W'(pos_ff[0]);
         e_ff[1] <= DIFF_W'(pos_ff[4]) - DIFF_W'(pos_ff[1]);
         e_ff[2] <= DIFF_W'(pos_ff[5]) - DIFF_W'(pos_ff[2]);
         e_ff[3] <= DIFF_W'(req_vert_x) - DIFF_W'(pos_ff[0]);
         e_ff[4] <= DIFF_W'(req_vert_y) - DIFF_W'(pos_ff[1]);
         e_ff[5] <= DIFF_W'(req_vert_z) - DIFF_W'(pos_ff[2]);
         e_ff[6] <= DIFF_W'(req_hit_x) - DIFF_W'(pos_ff[0]);
         e_ff[7] <= DIFF_W'(req_hit_y) - DIFF_W'(pos_ff[1]);
         e_ff[8] <= DIFF_W'(req_hit_z) - DIFF_W'(pos_ff[2]);
         nc_ff[0] <= req_norm_x;
         nc_ff[1] <= req_norm_y;
         nc_ff[2] <= req_norm_z;
      end
      if (state_ff == ST_ABS) begin
         mag_or_ff <= or_c;
         for (int i = 0; i < 9; i++) begin
            mag_ff[i] <= abs_c[i];
            sgn_ff[i] <= e_ff[i][DIFF_W-1];
         end
      end else if (state_ff == ST_SCALE) begin
         // Shifting the magnitudes step by step truncates toward zero overall.
         if (hi8) begin
            mag_or_ff <= mag_or_ff >> SHIFT_JUMP;
            for (int i = 0; i < 9; i++) mag_ff[i] <= mag_ff[i] >> SHIFT_JUMP;
         end else if (hi1) begin
            mag_or_ff <= mag_or_ff >> 1;
            for (int i = 0; i < 9; i++) mag_ff[i] <= mag_ff[i] >> 1;
         end
      end
      if (state_ff == ST_FIX) begin
         for (int i = 0; i < 9; i++) begin
            es_ff[i] <= sgn_ff[i] ? -signed'({1'b0, mag_ff[i][FRAC_BITS-1:0]})
                                  :  signed'({1'b0, mag_ff[i][FRAC_BITS-1:0]});
         end
      end
   end

   // Operand selection for the shared multiplier.
   function automatic logic signed [MUL_W-1:0] pick(input operand_type s);
      logic signed [MUL_W-1:0] r;
      unique case (s)
         OPD_E0:  r = MUL_W'(es_ff[0]);
         OPD_E1:  r = MUL_W'(es_ff[1]);
         OPD_E2:  r = MUL_W'(es_ff[2]);
         OPD_E3:  r = MUL_W'(es_ff[3]);
         OPD_E4:  r = MUL_W'(es_ff[4]);
         OPD_E5:  r = MUL_W'(es_ff[5]);
         OPD_E6:  r = MUL_W'(es_ff[6]);
         OPD_E7:  r = MUL_W'(es_ff[7]);
         OPD_E8:  r = MUL_W'(es_ff[8]);
         OPD_D00: r = d00_ff;
         OPD_D01: r = d01_ff;
         OPD_D11: r = d11_ff;
         OPD_D20: r = d20_ff;
         OPD_D21: r = d21_ff;
         OPD_WU:  r = MUL_W'(wu_ff);
         OPD_WV:  r = MUL_W'(wv_ff);
         OPD_WW:  r = MUL_W'(ww_ff);
         OPD_NA0: r = MUL_W'(nrm_ff[0]);
         OPD_NA1: r = MUL_W'(nrm_ff[1]);
         OPD_NA2: r = MUL_W'(nrm_ff[2]);
         OPD_NB0: r = MUL_W'(nrm_ff[3]);
         OPD_NB1: r = MUL_W'(nrm_ff[4]);
         OPD_NB2: r = MUL_W'(nrm_ff[5]);
         OPD_NC0: r = MUL_W'(nc_ff[0]);
         OPD_NC1: r = MUL_W'(nc_ff[1]);
         OPD_NC2: r = MUL_W'(nc_ff[2]);
         default: r = '0;
      endcase
      return r;
   endfunction

   assign cur_op = mac_op(op_ff);

   always_comb begin
      mac_ctrl.en    = (state_ff == ST_MAC1) || (state_ff == ST_MAC2);
      mac_ctrl.first = cur_op.first;
      mac_ctrl.neg   = cur_op.neg;
      opa            = pick(cur_op.src_a);
      opb            = pick(cur_op.src_b);
   end

   bni_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .opa   (opa),
      .opb   (opb),
      .acc   (acc)
   );

   assign div_start = ((state_ff == ST_CHECK) && (den_ff > 0)) ||
                      ((state_ff == ST_DIVV) && div_done);
   assign div_num   = (state_ff == ST_DIVV) ? numw_ff : numv_ff;

   bni_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign acc_sat = sat_out(shrink_frac(acc));
   assign u_sat   = sat_out(ACC_W'(ONE_Q14) - ACC_W'(wv_ff) - ACC_W'(ww_ff));

   // An accumulation group lands in its destination in the cycle after its last pass.
   always_ff @(posedge clock) begin
      unique case (wr_dst_ff)
         DST_D00:  d00_ff  <= acc[MUL_W-1:0];
         DST_D01:  d01_ff  <= acc[MUL_W-1:0];
         DST_D11:  d11_ff  <= acc[MUL_W-1:0];
         DST_D20:  d20_ff  <= acc[MUL_W-1:0];
         DST_D21:  d21_ff  <= acc[MUL_W-1:0];
         DST_DEN:  den_ff  <= acc;
         DST_NUMV: numv_ff <= acc;
         DST_NUMW: numw_ff <= acc;
         DST_NX:   nx_ff   <= acc_sat;
         DST_NY:   ny_ff   <= acc_sat;
         DST_NZ:   nz_ff   <= acc_sat;
         default: ;
      endcase
      if (state_ff == ST_CHECK) begin
         deg_ff <= (den_ff <= 0);
      end
      if ((state_ff == ST_DIVV) && div_done) begin
         wv_ff <= div_quot;
      end
      if ((state_ff == ST_DIVW) && div_done) begin
         ww_ff <= div_quot;
      end
      if (state_ff == ST_UCALC) begin
         wu_ff <= u_sat;
      end
   end

   // Sequencer.
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      wr_dst_in    = DST_NONE;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start_tri) state_in = ST_ABS;
         end
         ST_ABS: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (!hi1) state_in = ST_FIX;
         end
         ST_FIX: begin
            op_in    = FIRST_OP1;
            state_in = ST_MAC1;
         end
         ST_MAC1: begin
            wr_dst_in = cur_op.dst;
            op_in     = op_ff + 1'b1;
            if (op_ff == LAST_OP1) state_in = ST_DRAIN1;
         end
         ST_DRAIN1: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = (den_ff > 0) ? ST_DIVV : ST_OUT;
         end
         ST_DIVV: begin
            if (div_done) state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) state_in = ST_UCALC;
         end
         ST_UCALC: begin
            op_in    = FIRST_OP2;
            state_in = ST_MAC2;
         end
         ST_MAC2: begin
            wr_dst_in = cur_op.dst;
            op_in     = op_ff + 1'b1;
            if (op_ff == LAST_OP2) state_in = ST_DRAIN2;
         end
         ST_DRAIN2: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= FIRST_OP1;
         wr_dst_ff    <= DST_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         wr_dst_ff    <= wr_dst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output word register; a degenerate triangle reports all zeros.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_deg_ff <= deg_ff;
         rsp_nx_ff  <= deg_ff ? '0 : nx_ff;
         rsp_ny_ff  <= deg_ff ? '0 : ny_ff;
         rsp_nz_ff  <= deg_ff ? '0 : nz_ff;
         rsp_wu_ff  <= deg_ff ? '0 : wu_ff;
         rsp_wv_ff  <= deg_ff ? '0 : wv_ff;
         rsp_ww_ff  <= deg_ff ? '0 : ww_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_norm_x = rsp_nx_ff;
   assign rsp_out_norm_y = rsp_ny_ff;
   assign rsp_out_norm_z = rsp_nz_ff;
   assign rsp_weight_u   = rsp_wu_ff;
   assign rsp_weight_v   = rsp_wv_ff;
   assign rsp_weight_w   = rsp_ww_ff;
   assign rsp_degenerate = rsp_deg_ff;

   a_mac1_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC1) |-> (op_ff <= LAST_OP1))
      else $error("first accumulation phase ran past its last pass");

   a_div_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVV || state_ff == ST_DIVW))
      else $error("divider finished outside a divide state");

   a_scaled_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> ((mag_or_ff >> FRAC_BITS) == '0))
      else $error("block scaling left an edge component too large");

   a_div_den_positive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVV) |-> (den_ff > 0))
      else $error("division started with a non-positive denominator");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_weight_u == '0 && rsp_weight_v == '0 &&
         rsp_weight_w == '0 && rsp_out_norm_x == '0 && rsp_out_norm_y == '0 &&
         rsp_out_norm_z == '0))
      else $error("degenerate word carries nonzero fields");

endmodule

/* sim/barycentric_normal_interpolator_test.sv */
// ----------------------------------------------------------------------------
// Barycentric normal interpolator testbench
// Feeds triangles as corner words, predicts weights and blended normals with a
// local fixed-point model, and checks every response word in order.
// ----------------------------------------------------------------------------
module barycentric_normal_interpolator_test;
   import bni_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int NW = NORMAL_WIDTH_DEF;
   localparam logic [1:0] SLOT_A = 2'd0, SLOT_B = 2'd1, SLOT_C = 2'd2, SLOT_NONE = 2'd3;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [1:0] slot;
      logic signed [CW-1:0] vx, vy, vz, hx, hy, hz;
      logic signed [NW-1:0] nx, ny, nz;
   } corner_word_t;

   typedef struct {
      logic signed [OUT_W-1:0] nx, ny, nz, wu, wv, ww;
      logic degen;
   } shade_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_vertex_slot = '0;
   logic signed [CW-1:0] req_vert_x = '0, req_vert_y = '0, req_vert_z = '0;
   logic signed [NW-1:0] req_norm_x = '0, req_norm_y = '0, req_norm_z = '0;
   logic signed [CW-1:0] req_hit_x = '0, req_hit_y = '0, req_hit_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_out_norm_x, rsp_out_norm_y, rsp_out_norm_z;
   logic signed [OUT_W-1:0] rsp_weight_u, rsp_weight_v, rsp_weight_w;
   logic rsp_degenerate;

   corner_word_t pending_words[$];
   shade_word_t expected_shades[$];
   longint stored_pos[6];
   longint stored_nrm[6];
   int errors = 0;
   int shades_seen = 0;
   int degenerate_seen = 0;
   longint cycles = 0;
   bit calm = 1'b0;
   bit hold_send = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;

   barycentric_normal_interpolator DUT (.*);

   always #5 clock = ~clock;

   function automatic longint trunc_shift(longint x, int s);
      longint m;
      m = x < 0 ? -x : x;
      m = m >> s;
      return x < 0 ? -m : m;
   endfunction

   function automatic longint clamp18(longint x);
      if (x > 131071) return 131071;
      if (x < -131072) return -131072;
      return x;
   endfunction

   function automatic longint weight_div(longint num, longint den);
      longint mag, q, r;
      mag = num < 0 ? -num : num;
      if (mag >= 8 * den) return num < 0 ? -131072 : 131071;
      q = mag / den;
      r = mag % den;
      for (int i = 0; i < FRAC_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return num < 0 ? -q : q;
   endfunction

   // Updates the stored corners and, on the third corner, returns the shading result.
   function automatic bit shade_predict(corner_word_t c, output shade_word_t r);
      longint e[9], pc[3], ph[3], nc[3];
      longint m, d00, d01, d11, d20, d21, den, wu, wv, ww, acc;
      int s;
      r = '{default: 0};
      if (c.slot == SLOT_NONE) return 1'b0;
      if (c.slot != SLOT_C) begin
         stored_pos[c.slot*3] = c.vx; stored_pos[c.slot*3+1] = c.vy;
         stored_pos[c.slot*3+2] = c.vz;
         stored_nrm[c.slot*3] = c.nx; stored_nrm[c.slot*3+1] = c.ny;
         stored_nrm[c.slot*3+2] = c.nz;
         return 1'b0;
      end
      pc = '{c.vx, c.vy, c.vz};
      ph = '{c.hx, c.hy, c.hz};
      nc = '{c.nx, c.ny, c.nz};
      m = 0;
      for (int i = 0; i < 3; i++) begin
         e[i] = stored_pos[3+i] - stored_pos[i];
         e[3+i] = pc[i] - stored_pos[i];
         e[6+i] = ph[i] - stored_pos[i];
      end
      foreach (e[i]) if ((e[i] < 0 ? -e[i] : e[i]) > m) m = e[i] < 0 ? -e[i] : e[i];
      s = 0;
      while ((m >> s) >= ONE_Q14) s++;
      foreach (e[i]) e[i] = trunc_shift(e[i], s);
      d00 = e[0]*e[0] + e[1]*e[1] + e[2]*e[2];
      d01 = e[0]*e[3] + e[1]*e[4] + e[2]*e[5];
      d11 = e[3]*e[3] + e[4]*e[4] + e[5]*e[5];
      d20 = e[6]*e[0] + e[7]*e[1] + e[8]*e[2];
      d21 = e[6]*e[3] + e[7]*e[4] + e[8]*e[5];
      den = d00*d11 - d01*d01;
      if (den <= 0) begin
         r.degen = 1'b1;
         return 1'b1;
      end
      wv = weight_div(d11*d20 - d01*d21, den);
      ww = weight_div(d00*d21 - d01*d20, den);
      wu = clamp18(ONE_Q14 - wv - ww);
      acc = wu*stored_nrm[0] + wv*stored_nrm[3] + ww*nc[0];
      r.nx = OUT_W'(clamp18(trunc_shift(acc, FRAC_BITS)));
      acc = wu*stored_nrm[1] + wv*stored_nrm[4] + ww*nc[1];
      r.ny = OUT_W'(clamp18(trunc_shift(acc, FRAC_BITS)));
      acc = wu*stored_nrm[2] + wv*stored_nrm[5] + ww*nc[2];
      r.nz = OUT_W'(clamp18(trunc_shift(acc, FRAC_BITS)));
      r.wu = OUT_W'(wu); r.wv = OUT_W'(wv); r.ww = OUT_W'(ww);
      return 1'b1;
   endfunction

   function automatic corner_word_t make_corner(logic [1:0] slot, int spread);
      corner_word_t c;
      c.slot = slot;
      c.vx = $signed($urandom) >>> spread; c.vy = $signed($urandom) >>> spread;
      c.vz = $signed($urandom) >>> spread;
      c.hx = $signed($urandom) >>> spread; c.hy = $signed($urandom) >>> spread;
      c.hz = $signed($urandom) >>> spread;
      c.nx = NW'($urandom); c.ny = NW'($urandom); c.nz = NW'($urandom);
      return c;
   endfunction

   // Driver: one word offered at a time, held until accepted.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid && req_ready) void'(pending_words.pop_front());
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 8);
            req_valid <= 1'b0;
         end else if (hold_send || pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            corner_word_t c;
            c = pending_words[0];
            req_valid <= 1'b1;
            req_vertex_slot <= c.slot;
            req_vert_x <= c.vx; req_vert_y <= c.vy; req_vert_z <= c.vz;
            req_norm_x <= c.nx; req_norm_y <= c.ny; req_norm_z <= c.nz;
            req_hit_x <= c.hx; req_hit_y <= c.hy; req_hit_z <= c.hz;
         end
      end
   end

   // Prediction at acceptance keeps the model in step with the block.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         corner_word_t c;
         shade_word_t r;
         c.slot = req_vertex_slot;
         c.vx = req_vert_x; c.vy = req_vert_y; c.vz = req_vert_z;
         c.nx = req_norm_x; c.ny = req_norm_y; c.nz = req_norm_z;
         c.hx = req_hit_x; c.hy = req_hit_y; c.hz = req_hit_z;
         if (shade_predict(c, r)) expected_shades.push_back(r);
      end
   end

   // Monitor: checks each accepted response word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_shades.size() == 0) begin
            $display("%0t: unexpected response word, actual nx=%0d u=%0d degen=%0b",
                     $time, rsp_out_norm_x, rsp_weight_u, rsp_degenerate);
            errors <= errors + 1;
         end else begin
            shade_word_t x;
            x = expected_shades.pop_front();
            shades_seen <= shades_seen + 1;
            if (rsp_degenerate) degenerate_seen <= degenerate_seen + 1;
            if (x.nx !== rsp_out_norm_x || x.ny !== rsp_out_norm_y ||
                x.nz !== rsp_out_norm_z || x.wu !== rsp_weight_u ||
                x.wv !== rsp_weight_v || x.ww !== rsp_weight_w ||
                x.degen !== rsp_degenerate) begin
               $display("%0t: mismatch expected n=(%0d,%0d,%0d) w=(%0d,%0d,%0d) d=%0b",
                        $time, x.nx, x.ny, x.nz, x.wu, x.wv, x.ww, x.degen);
               $display("%0t:          actual n=(%0d,%0d,%0d) w=(%0d,%0d,%0d) d=%0b",
                        $time, rsp_out_norm_x, rsp_out_norm_y, rsp_out_norm_z,
                        rsp_weight_u, rsp_weight_v, rsp_weight_w, rsp_degenerate);
               errors <= errors + 1;
            end
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         recv_gap <= $urandom_range(1, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic add_triangle(corner_word_t a, corner_word_t b, corner_word_t c);
      a.slot = SLOT_A; b.slot = SLOT_B; c.slot = SLOT_C;
      pending_words.push_back(a);
      pending_words.push_back(b);
      pending_words.push_back(c);
   endtask

   task automatic add_point(corner_word_t base, longint x, longint y, longint z,
                            output corner_word_t c);
      c = base;
      c.vx = CW'(x); c.vy = CW'(y); c.vz = CW'(z);
   endtask

   initial begin
      corner_word_t a, b, c, z;
      int spread;
      z = make_corner(SLOT_A, 0);
      z.vx = '0; z.vy = '0; z.vz = '0; z.hx = '0; z.hy = '0; z.hz = '0;
      z.nx = 16'sd16384; z.ny = '0; z.nz = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Unit right triangle with the hit at the centroid and at a corner.
      a = z;
      add_point(z, 65536, 0, 0, b); b.nx = '0; b.ny = 16'sd16384;
      add_point(z, 0, 65536, 0, c); c.nx = '0; c.nz = 16'sd16384;
      c.hx = 32'sd21845; c.hy = 32'sd21845;
      add_triangle(a, b, c);
      c.hx = 32'sd65536; c.hy = '0;
      add_triangle(a, b, c);
      // Hit far outside, so the weights saturate.
      c.hx = 32'sh7fffffff; c.hy = -32'sh7fffffff;
      add_triangle(a, b, c);
      // Collinear corners and coincident corners give a zero denominator.
      add_point(z, 131072, 0, 0, c);
      add_triangle(a, b, c);
      add_triangle(a, a, a);
      // Extreme coordinates and normals.
      a = z; a.vx = 32'sh80000000; a.vy = 32'sh80000000; a.vz = 32'sh7fffffff;
      a.nx = 16'sh8000; a.ny = 16'sh7fff; a.nz = 16'sh8000;
      b = a; b.vx = 32'sh7fffffff; b.nx = 16'sh7fff; b.nz = 16'sh7fff;
      c = a; c.vy = 32'sh7fffffff; c.vz = 32'sh80000000; c.ny = 16'sh8000;
      c.hx = 32'sh80000000; c.hy = 32'sh7fffffff; c.hz = 32'sh80000000;
      add_triangle(a, b, c);
      // An ignored slot between corners must leave the stored ones alone.
      pending_words.push_back(a);
      pending_words.push_back(b);
      pending_words.push_back(make_corner(SLOT_NONE, 0));
      pending_words.push_back(c);

      // Random triangles over a range of sizes, with some reuse and noise.
      for (int t = 0; t < 465; t++) begin
         spread = $urandom_range(0, 4) == 0 ? $urandom_range(0, 31) : $urandom_range(8, 20);
         if (t == 445) calm = 1'b1;
         if (t == 230) begin
            wait (pending_words.size() == 0);
            hold_send = 1'b1;
            @(posedge clock);
            wait (expected_shades.size() == 0);
            hold_send = 1'b0;
         end
         case ($urandom_range(0, 9))
            0: pending_words.push_back(make_corner(SLOT_NONE, spread));
            1: pending_words.push_back(make_corner(SLOT_C, spread));
            2: pending_words.push_back(make_corner(2'($urandom_range(0, 1)), spread));
            default: ;
         endcase
         add_triangle(make_corner(SLOT_A, spread), make_corner(SLOT_B, spread),
                      make_corner(SLOT_C, spread));
         while (pending_words.size() > 16) @(posedge clock);
      end

      wait (pending_words.size() == 0);
      @(posedge clock);
      wait (expected_shades.size() == 0);
      repeat (200) @(posedge clock);
      $display("Checked %0d shading results, %0d of them degenerate triangles.",
               shades_seen, degenerate_seen);
      if (errors == 0 && expected_shades.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
design/bni_pkg.sv
design/bni_mac.sv
design/bni_div.sv
design/barycentric_normal_interpolator.sv
sim/barycentric_normal_interpolator_test.sv
